>>> rtl/core/pae_pkg.sv
// ----------------------------------------------------------------------------
// pae_pkg
// Shared types and constants for the pixel alpha extraction pipeline.
// ----------------------------------------------------------------------------
package pae_pkg;

  // source format codes held in the configuration register
  typedef enum logic [3:0] {
    FMT_A16UNORM = 4'd0,
    FMT_OPAQUE   = 4'd1,
    FMT_ARGB4444 = 4'd2,
    FMT_8888     = 4'd3,
    FMT_1010102  = 4'd4,
    FMT_F16RGBA  = 4'd5,
    FMT_F32      = 4'd6,
    FMT_A16HALF  = 4'd7,
    FMT_XR10     = 4'd8,
    FMT_RGBA16   = 4'd9
  } fmt_t;

  localparam logic [3:0] FMT_RESET = 4'd3;

  localparam int unsigned MANT_W  = 24;
  localparam int unsigned SHIFT_W = 6;
  localparam int unsigned PROD_W  = 32;

  // extended-range alpha offset
  localparam logic [9:0] XR10_BIAS = 10'd384;

  // decoded item: either a finished alpha or a significand and right shift
  typedef struct packed {
    logic                 direct;
    logic [7:0]           alpha;
    logic [MANT_W-1:0]    mant;
    logic [SHIFT_W-1:0]   shift;
  } dec_t;

  // scaled item: 255 * significand, still to be shifted
  typedef struct packed {
    logic                 direct;
    logic [7:0]           alpha;
    logic [PROD_W-1:0]    prod;
    logic [SHIFT_W-1:0]   shift;
  } prod_t;

endpackage

>>> rtl/core/pae_decode.sv
// ----------------------------------------------------------------------------
// pae_decode
// Stage 1: picks the alpha field for the selected format; integer formats and
// out-of-range floats finish here, others yield a significand and right shift.
// ----------------------------------------------------------------------------
module pae_decode (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [3:0]         source_format,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [63:0]        in_pixel_word,
  output logic               dec_valid,
  input  logic               dec_ready,
  output pae_pkg::dec_t      dec_data
);

  // half float decode
  function automatic pae_pkg::dec_t dec_half(input logic [15:0] h);
    pae_pkg::dec_t d;
    logic [4:0]    ef;
    logic [4:0]    eeff;
    ef   = h[14:10];
    eeff = (ef == 5'd0) ? 5'd1 : ef;
    d.direct = 1'b1;
    d.alpha  = 8'd0;
    d.mant   = '0;
    d.shift  = '0;
    if (ef == 5'd31) begin
      d.alpha = ((h[9:0] == 10'd0) && !h[15]) ? 8'hff : 8'd0;
    end else if (h[15]) begin
      d.alpha = 8'd0;
    end else if (ef >= 5'd15) begin
      d.alpha = 8'hff;
    end else begin
      d.direct = 1'b0;
      d.mant   = {13'd0, (ef != 5'd0), h[9:0]};
      d.shift  = 6'd25 - {1'b0, eeff};
    end
    return d;
  endfunction

  // single float decode
  function automatic pae_pkg::dec_t dec_single(input logic [31:0] f);
    pae_pkg::dec_t d;
    logic [7:0]    ef;
    logic [7:0]    eeff;
    logic [7:0]    sh;
    ef   = f[30:23];
    eeff = (ef == 8'd0) ? 8'd1 : ef;
    sh   = 8'd150 - eeff;
    d.direct = 1'b1;
    d.alpha  = 8'd0;
    d.mant   = '0;
    d.shift  = '0;
    if (ef == 8'd255) begin
      d.alpha = ((f[22:0] == 23'd0) && !f[31]) ? 8'hff : 8'd0;
    end else if (f[31]) begin
      d.alpha = 8'd0;
    end else if (ef >= 8'd127) begin
      d.alpha = 8'hff;
    end else if (sh >= 8'd40) begin
      d.alpha = 8'd0;
    end else begin
      d.direct = 1'b0;
      d.mant   = {(ef != 8'd0), f[22:0]};
      d.shift  = sh[5:0];
    end
    return d;
  endfunction

  logic          valid_r;
  pae_pkg::dec_t data_r;
  pae_pkg::dec_t data_nxt;
  logic [9:0]    xr_raw;
  logic [9:0]    xr_diff;

  assign in_ready  = !valid_r || dec_ready;
  assign dec_valid = valid_r;
  assign dec_data  = data_r;

  assign xr_raw  = in_pixel_word[63:54];
  assign xr_diff = xr_raw - pae_pkg::XR10_BIAS;

  // format select
  always_comb begin
    data_nxt        = '0;
    data_nxt.direct = 1'b1;
    case (source_format)
      pae_pkg::FMT_A16UNORM: data_nxt.alpha = in_pixel_word[15:8];
      pae_pkg::FMT_OPAQUE:   data_nxt.alpha = 8'hff;
      pae_pkg::FMT_ARGB4444: data_nxt.alpha = {in_pixel_word[3:0], in_pixel_word[3:0]};
      pae_pkg::FMT_8888:     data_nxt.alpha = in_pixel_word[31:24];
      pae_pkg::FMT_1010102:  data_nxt.alpha = {4{in_pixel_word[31:30]}};
      pae_pkg::FMT_F16RGBA:  data_nxt = dec_half(in_pixel_word[63:48]);
      pae_pkg::FMT_F32:      data_nxt = dec_single(in_pixel_word[31:0]);
      pae_pkg::FMT_A16HALF:  data_nxt = dec_half(in_pixel_word[15:0]);
      pae_pkg::FMT_XR10: begin
        if (xr_raw < pae_pkg::XR10_BIAS) begin
          data_nxt.alpha = 8'd0;
        end else if (xr_diff[9]) begin
          data_nxt.alpha = 8'hff;
        end else begin
          data_nxt.alpha = xr_diff[8:1];
        end
      end
      pae_pkg::FMT_RGBA16:   data_nxt.alpha = in_pixel_word[63:56];
      default:               data_nxt.alpha = 8'd0;
    endcase
  end

  // stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

>>> rtl/core/pae_mult.sv
// ----------------------------------------------------------------------------
// pae_mult
// Stage 2: scales the float significand by 255 (shift and subtract).
// ----------------------------------------------------------------------------
module pae_mult (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               dec_valid,
  output logic               dec_ready,
  input  pae_pkg::dec_t      dec_data,
  output logic               prod_valid,
  input  logic               prod_ready,
  output pae_pkg::prod_t     prod_data
);

  logic           valid_r;
  pae_pkg::prod_t data_r;
  pae_pkg::prod_t data_nxt;

  assign dec_ready  = !valid_r || prod_ready;
  assign prod_valid = valid_r;
  assign prod_data  = data_r;

  // 255 * m = (m << 8) - m
  always_comb begin
    data_nxt.direct = dec_data.direct;
    data_nxt.alpha  = dec_data.alpha;
    data_nxt.shift  = dec_data.shift;
    data_nxt.prod   = {dec_data.mant, 8'h00} - {8'h00, dec_data.mant};
  end

  // stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (dec_ready) begin
      valid_r <= dec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (dec_ready && dec_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

>>> rtl/core/pae_scale.sv
// ----------------------------------------------------------------------------
// pae_scale
// Stage 3: truncating right shift of the scaled significand, final alpha
// select and output register.
// ----------------------------------------------------------------------------
module pae_scale (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               prod_valid,
  output logic               prod_ready,
  input  pae_pkg::prod_t     prod_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_alpha_byte
);

  logic        valid_r;
  logic [7:0]  alpha_r;
  logic [7:0]  alpha_nxt;
  logic [31:0] shifted;

  assign prod_ready     = !valid_r || out_ready;
  assign out_valid      = valid_r;
  assign out_alpha_byte = alpha_r;

  // value is below one here, so the shifted product fits in a byte
  assign shifted   = prod_data.prod >> prod_data.shift;
  assign alpha_nxt = prod_data.direct ? prod_data.alpha : shifted[7:0];

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (prod_ready) begin
      valid_r <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_ready && prod_valid) begin
      alpha_r <= alpha_nxt;
    end
  end

endmodule

>>> rtl/core/pixel_alpha_extract_top.sv
// Pipeline: 3 register stages (decode, scale, shift); an accepted item is
// registered by each stage in turn, and out_valid rises once it sits in the
// output register of the shift stage.
// Throughput: one item per cycle while out_ready is high; each stage holds one
// item and moves on as soon as the stage after it is empty or draining.
// Reset: synchronous active-low rst_n empties all stages and sets the source
// format to 8888.
// ----------------------------------------------------------------------------
// pixel_alpha_extract_top
// Extracts an 8-bit alpha from one source pixel word in the configured format.
// ----------------------------------------------------------------------------
module pixel_alpha_extract_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_pixel_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_alpha_byte
);

  logic [3:0]     fmt_r;
  logic           dec_valid;
  logic           dec_ready;
  pae_pkg::dec_t  dec_data;
  logic           prod_valid;
  logic           prod_ready;
  pae_pkg::prod_t prod_data;

  // format register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= pae_pkg::FMT_RESET;
    end else if (cfg_wr_en) begin
      fmt_r <= cfg_wr_data;
    end
  end

  pae_decode u_decode (
    .clk           (clk),
    .rst_n         (rst_n),
    .source_format (fmt_r),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_pixel_word (in_pixel_word),
    .dec_valid     (dec_valid),
    .dec_ready     (dec_ready),
    .dec_data      (dec_data)
  );

  pae_mult u_mult (
    .clk        (clk),
    .rst_n      (rst_n),
    .dec_valid  (dec_valid),
    .dec_ready  (dec_ready),
    .dec_data   (dec_data),
    .prod_valid (prod_valid),
    .prod_ready (prod_ready),
    .prod_data  (prod_data)
  );

  pae_scale u_scale (
    .clk            (clk),
    .rst_n          (rst_n),
    .prod_valid     (prod_valid),
    .prod_ready     (prod_ready),
    .prod_data      (prod_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_alpha_byte (out_alpha_byte)
  );

endmodule

>>> verif/pixel_alpha_extract_top_tb.sv
// ----------------------------------------------------------------------------
// pixel_alpha_extract_top_tb
// Self-checking bench for the alpha extractor. A short table of hand-picked
// pixels per source format runs first, then random pixels in phases, one
// format per phase, with the format register rewritten between phases once
// the pipeline has drained. Items are scored against a behavioural alpha
// decoder or a hand-set probe alpha, with random idling on both channels.
// ----------------------------------------------------------------------------
module pixel_alpha_extract_top_tb;

  // format codes that no source uses
  localparam logic [3:0] FMT_SPARE_FIRST = 4'd10;
  localparam logic [3:0] FMT_SPARE_LAST  = 4'd15;

  localparam int RANDOM_PHASES = 26;
  localparam int HOLD_AT       = 350;
  localparam int HOLD_CYCLES   = 60;
  localparam int TAIL_CYCLES   = 8;
  localparam int CYCLE_LIMIT   = 200000;

  // one hand-picked pixel; alpha is only used when literal is set
  typedef struct packed {
    logic [3:0]  fmt;
    logic [63:0] word;
    logic        literal;
    logic [7:0]  alpha;
  } probe_t;

  localparam int NPROBES = 25;
  localparam probe_t PROBES [NPROBES] = '{
    '{pae_pkg::FMT_8888,     64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 8'hFF},
    '{pae_pkg::FMT_8888,     64'h0000_0000_0000_0000, 1'b1, 8'h00},
    '{pae_pkg::FMT_A16UNORM, 64'hFFFF_FFFF_FFFF_00FF, 1'b1, 8'h00},
    '{pae_pkg::FMT_A16UNORM, 64'h0000_0000_0000_FF00, 1'b1, 8'hFF},
    '{pae_pkg::FMT_OPAQUE,   64'h0000_0000_0000_0000, 1'b1, 8'hFF},
    '{pae_pkg::FMT_ARGB4444, 64'hFFFF_FFFF_FFFF_FFF0, 1'b1, 8'h00},
    '{pae_pkg::FMT_ARGB4444, 64'h0000_0000_0000_000F, 1'b1, 8'hFF},
    '{pae_pkg::FMT_1010102,  64'h0000_0000_4000_0000, 1'b0, 8'h00},
    '{pae_pkg::FMT_1010102,  64'h0000_0000_C000_0000, 1'b1, 8'hFF},
    '{pae_pkg::FMT_F16RGBA,  64'h3C00_0000_0000_0000, 1'b1, 8'hFF},
    '{pae_pkg::FMT_F16RGBA,  64'h7E00_0000_0000_0000, 1'b1, 8'h00},
    '{pae_pkg::FMT_F16RGBA,  64'h8000_FFFF_FFFF_FFFF, 1'b1, 8'h00},
    '{pae_pkg::FMT_F32,      64'h0000_0000_7F80_0000, 1'b1, 8'hFF},
    '{pae_pkg::FMT_F32,      64'hFFFF_FFFF_FF80_0000, 1'b1, 8'h00},
    '{pae_pkg::FMT_F32,      64'h0000_0000_3F7F_FFFF, 1'b0, 8'h00},
    '{pae_pkg::FMT_F32,      64'h0000_0000_0000_0001, 1'b1, 8'h00},
    '{pae_pkg::FMT_A16HALF,  64'h0000_0000_0000_3BFF, 1'b0, 8'h00},
    '{pae_pkg::FMT_A16HALF,  64'h0000_0000_0000_0001, 1'b0, 8'h00},
    '{pae_pkg::FMT_A16HALF,  64'hFFFF_FFFF_FFFF_FC00, 1'b1, 8'h00},
    '{pae_pkg::FMT_XR10,     64'h0000_0000_0000_0000, 1'b1, 8'h00},
    '{pae_pkg::FMT_XR10,     64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 8'hFF},
    '{pae_pkg::FMT_XR10,     {10'd385, 54'd0},        1'b0, 8'h00},
    '{pae_pkg::FMT_RGBA16,   {8'hFF, 56'd0},          1'b1, 8'hFF},
    '{FMT_SPARE_FIRST,       64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 8'h00},
    '{FMT_SPARE_LAST,        64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 8'h00}
  };

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [3:0]  cfg_wr_data;
  logic        in_valid;
  logic        in_ready;
  logic [63:0] in_pixel_word;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_alpha_byte;

  logic [7:0] alpha_due [$];
  logic [3:0] cur_fmt;
  int         fails;
  int         alphas_seen;
  int         cycles;

  pixel_alpha_extract_top DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pixel_word  (in_pixel_word),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_alpha_byte (out_alpha_byte)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // floor(255 * value) of a binary float, saturated, nan and negatives to 0
  function automatic logic [7:0] float_alpha(input logic sign, input int unsigned ef,
                                             input logic [31:0] frac,
                                             input int unsigned fbits,
                                             input int unsigned emax,
                                             input int unsigned bias);
    logic [63:0] mant;
    int unsigned eeff;
    int unsigned shift;
    if (ef == emax) begin
      if (frac != 0) return 8'h00;
      return sign ? 8'h00 : 8'hFF;
    end
    if (sign) return 8'h00;
    if (ef >= bias) return 8'hFF;
    mant  = (ef != 0) ? (64'(frac) | (64'd1 << fbits)) : 64'(frac);
    eeff  = (ef != 0) ? ef : 1;
    shift = bias + fbits - eeff;
    if (shift >= 40) return 8'h00;
    return 8'((64'd255 * mant) >> shift);
  endfunction

  function automatic logic [7:0] half_alpha(input logic [15:0] h);
    return float_alpha(h[15], 32'(h[14:10]), {22'd0, h[9:0]}, 10, 31, 15);
  endfunction

  // alpha that the block should return for a pixel in a given format
  function automatic logic [7:0] expected_alpha(input logic [3:0] fmt,
                                                input logic [63:0] w);
    logic [9:0] raw;
    case (fmt)
      pae_pkg::FMT_A16UNORM: return w[15:8];
      pae_pkg::FMT_OPAQUE:   return 8'hFF;
      pae_pkg::FMT_ARGB4444: return {w[3:0], w[3:0]};
      pae_pkg::FMT_8888:     return w[31:24];
      pae_pkg::FMT_1010102:  return 8'(w[31:30] * 8'h55);
      pae_pkg::FMT_F16RGBA:  return half_alpha(w[63:48]);
      pae_pkg::FMT_F32:
        return float_alpha(w[31], 32'(w[30:23]), {9'd0, w[22:0]}, 23, 255, 127);
      pae_pkg::FMT_A16HALF:  return half_alpha(w[15:0]);
      pae_pkg::FMT_XR10: begin
        raw = w[63:54];
        if (raw < pae_pkg::XR10_BIAS) return 8'h00;
        if (((raw - pae_pkg::XR10_BIAS) >> 1) > 10'd255) return 8'hFF;
        return 8'((raw - pae_pkg::XR10_BIAS) >> 1);
      end
      pae_pkg::FMT_RGBA16:   return w[63:56];
      default:               return 8'h00;
    endcase
  endfunction

  // half float biased towards the interesting range below one
  function automatic logic [15:0] random_half();
    logic [4:0] e;
    case ($urandom_range(0, 5))
      0:       e = 5'd0;
      1:       e = 5'd31;
      2:       e = 5'd15;
      default: e = 5'($urandom_range(5, 14));
    endcase
    return {($urandom_range(0, 7) == 0), e, 10'($urandom)};
  endfunction

  // random pixel; float and XR10 ones mostly shaped so that the alpha field lands near the edges
  function automatic logic [63:0] random_pixel(input logic [3:0] fmt);
    logic [63:0] w;
    logic [7:0]  e;
    w = {$urandom, $urandom};
    if ($urandom_range(0, 3) != 0) begin
      case (fmt)
        pae_pkg::FMT_F16RGBA: w[63:48] = random_half();
        pae_pkg::FMT_A16HALF: w[15:0]  = random_half();
        pae_pkg::FMT_F32: begin
          case ($urandom_range(0, 7))
            0:       e = 8'd0;
            1:       e = 8'd255;
            2:       e = 8'd127;
            default: e = 8'($urandom_range(110, 126));
          endcase
          w[31:0] = {($urandom_range(0, 7) == 0), e, 23'($urandom)};
        end
        pae_pkg::FMT_XR10:    w[63:54] = 10'($urandom_range(370, 900));
        default: ;
      endcase
    end
    return w;
  endfunction

  // offer one pixel, optionally after a random gap, and log its alpha
  task automatic offer_pixel(input logic [63:0] w, input logic [7:0] alpha, input bit steady);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_pixel_word <= w;
    do @(posedge clk); while (in_ready !== 1'b1);
    alpha_due.push_back(alpha);
  endtask

  // drain the pipeline, then rewrite the source format
  task automatic switch_format(input logic [3:0] fmt);
    in_valid <= 1'b0;
    while (alpha_due.size() != 0) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= fmt;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_fmt = fmt;
  endtask

  // stimulus
  initial begin : stimulus
    logic [63:0] w;
    logic [3:0]  fmt;
    bit          steady;
    int          count;
    rst_n         <= 1'b0;
    cfg_wr_en     <= 1'b0;
    cfg_wr_data   <= '0;
    in_valid      <= 1'b0;
    in_pixel_word <= '0;
    cur_fmt = pae_pkg::FMT_RESET;
    fails   = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // hand-picked pixels
    for (int i = 0; i < NPROBES; i++) begin
      if (PROBES[i].fmt != cur_fmt) switch_format(PROBES[i].fmt);
      offer_pixel(PROBES[i].word,
                  PROBES[i].literal ? PROBES[i].alpha
                                    : expected_alpha(cur_fmt, PROBES[i].word),
                  1'b0);
    end

    // random phases: every code once, then a random mix
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p <= FMT_SPARE_LAST)
        fmt = 4'(p);
      else if ($urandom_range(0, 7) == 0)
        fmt = 4'($urandom_range(FMT_SPARE_FIRST, FMT_SPARE_LAST));
      else
        fmt = 4'($urandom_range(pae_pkg::FMT_A16UNORM, pae_pkg::FMT_RGBA16));
      switch_format(fmt);
      steady = ($urandom_range(0, 3) == 0);
      count  = $urandom_range(28, 46);
      repeat (count) begin
        w = random_pixel(cur_fmt);
        offer_pixel(w, expected_alpha(cur_fmt, w), steady);
      end
    end

    // wind down
    in_valid <= 1'b0;
    while (alpha_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fails == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // result side: random stalls, calm stretches and one long hold
  initial begin : sink
    int  stall;
    bit  calm;
    out_ready <= 1'b0;
    alphas_seen = 0;
    calm = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (alphas_seen % 40 == 0) calm = ($urandom_range(0, 2) == 0);
      if (alphas_seen == HOLD_AT)
        stall = HOLD_CYCLES;
      else
        stall = calm ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      alphas_seen++;
      if (alpha_due.size() == 0) begin
        $error("alpha_byte with nothing outstanding: actual %0h", out_alpha_byte);
        fails++;
      end else begin
        if (out_alpha_byte !== alpha_due[0]) begin
          $error("alpha_byte mismatch: expected %0h actual %0h", alpha_due[0],
                 out_alpha_byte);
          fails++;
        end
        void'(alpha_due.pop_front());
      end
    end
  end

  // watchdog
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

endmodule
